// ===== design/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and codes for the binary heap priority queue unit.
// ----------------------------------------------------------------------------
package hpq_pkg;

   localparam int FIELD_W  = 32;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      RD_PARENT = 2'd0,
      RD_LAST   = 2'd1,
      RD_LEFT   = 2'd2,
      RD_RIGHT  = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      SRC_ITEM  = 2'd0,
      SRC_RD    = 2'd1,
      SRC_CHILD = 2'd2
   } wr_src_type;

   typedef enum logic [1:0] {
      POS_HOLD   = 2'd0,
      POS_PARENT = 2'd1,
      POS_LEFT   = 2'd2,
      POS_CHILD  = 2'd3
   } pos_sel_type;

   typedef struct packed {
      logic        accept;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_src_type  wr_src;
      pos_sel_type pos_sel;
      logic        capture_left;
      logic        capture_item;
      logic        load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic op_remove;
      logic empty;
      logic full;
      logic one_left;
      logic at_root;
      logic is_leaf;
      logic has_right;
      logic up_move;
      logic left_move;
      logic child_move;
   } dp_stat_type;

endpackage

// ===== design/hpq_ram.sv =====
// ----------------------------------------------------------------------------
// hpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpq_ctrl
// Sequencer for insert sift-up and remove sift-down; owns the handshakes.
// ----------------------------------------------------------------------------
module hpq_ctrl
   import hpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_CHECK,
      ST_UP_CMP,
      ST_DN_LAST,
      ST_DN_LOAD,
      ST_DN_CHECK,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_busy;

   assign rsp_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               cmd.accept = 1'b1;
               if (!stat.op_remove) begin
                  state_in = stat.full ? ST_DONE : ST_UP_CHECK;
               end else if (stat.empty || stat.one_left) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DN_LAST;
               end
            end
         end
         ST_UP_CHECK: begin
            if (stat.at_root) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = SRC_ITEM;
               state_in   = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
               state_in   = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.up_move) begin
               cmd.wr_src  = SRC_RD;
               cmd.pos_sel = POS_PARENT;
               state_in    = ST_UP_CHECK;
            end else begin
               cmd.wr_src = SRC_ITEM;
               state_in   = ST_DONE;
            end
         end
         ST_DN_LAST: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LAST;
            state_in   = ST_DN_LOAD;
         end
         ST_DN_LOAD: begin
            cmd.capture_item = 1'b1;
            state_in         = ST_DN_CHECK;
         end
         ST_DN_CHECK: begin
            if (stat.is_leaf) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = SRC_ITEM;
               state_in   = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LEFT;
               state_in   = ST_DN_LEFT;
            end
         end
         ST_DN_LEFT: begin
            if (stat.has_right) begin
               cmd.capture_left = 1'b1;
               cmd.rd_en        = 1'b1;
               cmd.rd_sel       = RD_RIGHT;
               state_in         = ST_DN_RIGHT;
            end else if (stat.left_move) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_src  = SRC_RD;
               cmd.pos_sel = POS_LEFT;
               state_in    = ST_DN_CHECK;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = SRC_ITEM;
               state_in   = ST_DONE;
            end
         end
         ST_DN_RIGHT: begin
            cmd.wr_en = 1'b1;
            if (stat.child_move) begin
               cmd.wr_src  = SRC_CHILD;
               cmd.pos_sel = POS_CHILD;
               state_in    = ST_DN_CHECK;
            end else begin
               cmd.wr_src = SRC_ITEM;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || rsp_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/hpq_datapath.sv =====
// ----------------------------------------------------------------------------
// hpq_datapath
// Heap store, position and count registers, key compares, result register.
// ----------------------------------------------------------------------------
module hpq_datapath
   import hpq_pkg::*;
#(
   parameter int CAPACITY      = 64,
   parameter int KEY_WIDTH     = 32,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  logic               csr_we,
   input  logic               csr_max_first,
   input  logic               req_type,
   input  logic [FIELD_W-1:0] req_key,
   input  logic [FIELD_W-1:0] req_payload,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0] rsp_count,
   output logic               rsp_head_valid,
   output logic [FIELD_W-1:0] rsp_head_key,
   output logic [FIELD_W-1:0] rsp_head_payload,
   output logic [FIELD_W-1:0] rsp_removed_key,
   output logic [FIELD_W-1:0] rsp_removed_payload
);

   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int POS2_W  = CNT_W + 1;
   localparam int ENTRY_W = KEY_WIDTH + PAYLOAD_WIDTH;

   function automatic logic precedes(input logic [KEY_WIDTH-1:0] a,
                                     input logic [KEY_WIDTH-1:0] b,
                                     input logic                 max_first);
      return max_first ? (a > b) : (a < b);
   endfunction

   logic                max_first_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [ENTRY_W-1:0]  item_ff, left_ff, head_ff;
   status_type          step_status_ff;
   logic [ENTRY_W-1:0]  step_removed_ff;
   status_type          rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_head_valid_ff;
   logic [ENTRY_W-1:0]  rsp_head_ff, rsp_removed_ff;

   logic                op_remove;
   logic [POS2_W-1:0]   pos_w, pos_x2, count_w, rd_addr_w;
   logic [CNT_W-1:0]    pos_m1;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [ENTRY_W-1:0]  rd_data, wr_data;
   logic [KEY_WIDTH-1:0] rd_key, item_key, left_key;
   logic                take_right;
   logic [CNT_W+COUNT_W-1:0] count_ext;

   assign op_remove = (op_type'(req_type) == OP_REMOVE);
   assign pos_w     = {1'b0, pos_ff};
   assign pos_x2    = {pos_ff, 1'b0};
   assign count_w   = {1'b0, count_ff};
   assign pos_m1    = pos_ff - CNT_W'(1);
   assign wr_addr   = pos_m1[ADDR_W-1:0];

   always_comb begin
      unique case (cmd.rd_sel)
         RD_PARENT: rd_addr_w = (pos_w >> 1) - POS2_W'(1);
         RD_LAST:   rd_addr_w = count_w;
         RD_LEFT:   rd_addr_w = pos_x2 - POS2_W'(1);
         RD_RIGHT:  rd_addr_w = pos_x2;
         default:   rd_addr_w = pos_x2;
      endcase
   end
   assign rd_addr = rd_addr_w[ADDR_W-1:0];

   assign rd_key   = rd_data[ENTRY_W-1:PAYLOAD_WIDTH];
   assign item_key = item_ff[ENTRY_W-1:PAYLOAD_WIDTH];
   assign left_key = left_ff[ENTRY_W-1:PAYLOAD_WIDTH];

   assign take_right = !precedes(left_key, rd_key, max_first_ff);

   always_comb begin
      unique case (cmd.wr_src)
         SRC_ITEM:  wr_data = item_ff;
         SRC_RD:    wr_data = rd_data;
         SRC_CHILD: wr_data = take_right ? rd_data : left_ff;
         default:   wr_data = item_ff;
      endcase
   end

   hpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.op_remove  = op_remove;
   assign stat.empty      = (count_ff == '0);
   assign stat.full       = (count_ff == CNT_W'(CAPACITY));
   assign stat.one_left   = (count_ff == CNT_W'(1));
   assign stat.at_root    = (pos_ff == CNT_W'(1));
   assign stat.is_leaf    = (pos_x2 > count_w);
   assign stat.has_right  = (pos_x2 < count_w);
   assign stat.up_move    = precedes(item_key, rd_key, max_first_ff);
   assign stat.left_move  = !precedes(item_key, rd_key, max_first_ff);
   assign stat.child_move = take_right ? !precedes(item_key, rd_key, max_first_ff)
                                       : !precedes(item_key, left_key, max_first_ff);

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      if (cmd.accept) begin
         if (!op_remove) begin
            if (!stat.full) begin
               count_in = count_ff + CNT_W'(1);
               pos_in   = count_ff + CNT_W'(1);
            end
         end else if (!stat.empty) begin
            count_in = count_ff - CNT_W'(1);
            pos_in   = CNT_W'(1);
         end
      end else begin
         unique case (cmd.pos_sel)
            POS_HOLD:   pos_in = pos_ff;
            POS_PARENT: pos_in = pos_ff >> 1;
            POS_LEFT:   pos_in = pos_x2[CNT_W-1:0];
            POS_CHILD:  pos_in = pos_x2[CNT_W-1:0] + CNT_W'(take_right);
            default:    pos_in = pos_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         max_first_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            max_first_ff <= csr_max_first;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.accept) begin
         item_ff <= {req_key[KEY_WIDTH-1:0], req_payload[PAYLOAD_WIDTH-1:0]};
         if (!op_remove) begin
            step_status_ff  <= stat.full ? STATUS_FULL : STATUS_OK;
            step_removed_ff <= '0;
         end else begin
            step_status_ff  <= stat.empty ? STATUS_EMPTY : STATUS_OK;
            step_removed_ff <= stat.empty ? '0 : head_ff;
         end
      end else if (cmd.capture_item) begin
         item_ff <= rd_data;
      end
      if (cmd.capture_left) begin
         left_ff <= rd_data;
      end
      if (cmd.wr_en && (wr_addr == '0)) begin
         head_ff <= wr_data;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff     <= step_status_ff;
         rsp_count_ff      <= count_ext[COUNT_W-1:0];
         rsp_head_valid_ff <= (count_ff != '0);
         rsp_head_ff       <= (count_ff != '0) ? head_ff : '0;
         rsp_removed_ff    <= step_removed_ff;
      end
   end

   assign count_ext = (CNT_W + COUNT_W)'(count_ff);

   assign rsp_status          = rsp_status_ff;
   assign rsp_count           = rsp_count_ff;
   assign rsp_head_valid      = rsp_head_valid_ff;
   assign rsp_head_key        = FIELD_W'(rsp_head_ff[ENTRY_W-1:PAYLOAD_WIDTH]);
   assign rsp_head_payload    = FIELD_W'(rsp_head_ff[PAYLOAD_WIDTH-1:0]);
   assign rsp_removed_key     = FIELD_W'(rsp_removed_ff[ENTRY_W-1:PAYLOAD_WIDTH]);
   assign rsp_removed_payload = FIELD_W'(rsp_removed_ff[PAYLOAD_WIDTH-1:0]);

endmodule

// ===== design/binary_heap_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit
// Fixed-capacity binary heap of key and payload entries, min or max first.
// ----------------------------------------------------------------------------
//  port group   direction  handshake            contents
//  req_*        in         req_valid/req_stall  req_type, req_key, req_payload
//  rsp_*        out        rsp_valid/rsp_stall  status, count, head, removed entry
//  csr_*        in         csr_valid/csr_ready  csr_max_first
//
//  One item at a time. Insert sifts the new entry up and remove sifts the last entry
//  down, one heap level at a time; the single read port of the heap RAM sets the
//  per-level cost. Error steps and removal of the only entry skip the sift.
//  Synchronous reset empties the queue; store contents are not cleared.
//  The next request is taken while a finished transfer waits on rsp_stall.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_unit
   import hpq_pkg::*;
#(
   parameter int CAPACITY      = 64,
   parameter int KEY_WIDTH     = 32,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [FIELD_W-1:0]  req_key,
   input  logic [FIELD_W-1:0]  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic                rsp_head_valid,
   output logic [FIELD_W-1:0]  rsp_head_key,
   output logic [FIELD_W-1:0]  rsp_head_payload,
   output logic [FIELD_W-1:0]  rsp_removed_key,
   output logic [FIELD_W-1:0]  rsp_removed_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_max_first
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   hpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   hpq_datapath #(
      .CAPACITY      (CAPACITY),
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_we              (csr_valid && csr_ready),
      .csr_max_first       (csr_max_first),
      .req_type            (req_type),
      .req_key             (req_key),
      .req_payload         (req_payload),
      .rsp_status          (rsp_status),
      .rsp_count           (rsp_count),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_key        (rsp_head_key),
      .rsp_head_payload    (rsp_head_payload),
      .rsp_removed_key     (rsp_removed_key),
      .rsp_removed_payload (rsp_removed_payload)
   );

endmodule

// ===== design/hpq_checker.sv =====
// ----------------------------------------------------------------------------
// hpq_checker
// Port-level checks for the binary heap priority queue unit.
// ----------------------------------------------------------------------------
module hpq_checker
   import hpq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [COUNT_W-1:0]  rsp_count,
   input logic                rsp_head_valid,
   input logic [FIELD_W-1:0]  rsp_head_key,
   input logic [FIELD_W-1:0]  rsp_head_payload,
   input logic [FIELD_W-1:0]  rsp_removed_key,
   input logic [FIELD_W-1:0]  rsp_removed_payload
);

   // one request in flight: an accepted transfer closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in flight");

   a_error_no_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         (rsp_removed_key == '0) && (rsp_removed_payload == '0))
      else $error("failed step reports a removed entry");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_valid |->
         (rsp_count == '0) && (rsp_head_key == '0) && (rsp_head_payload == '0))
      else $error("empty queue reports a head entry");

   a_remove_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> !rsp_head_valid)
      else $error("remove-on-empty with a head present");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_count) && $stable(rsp_head_key) && $stable(rsp_removed_key))
      else $error("stalled response changed");

endmodule

bind binary_heap_priority_queue_unit hpq_checker u_hpq_checker (.*);

// ===== test/binary_heap_priority_queue_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit_test
// Drives insert and remove requests through the heap queue with random gaps
// and response stalls. A local copy of the heap predicts each response, and
// every response transfer is compared field by field against it.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_unit_test;
   import hpq_pkg::*;

   localparam int CAPACITY  = 64;
   localparam int LIMIT     = 500000;
   localparam int WAVE_LEN  = 440;

   typedef struct {
      op_type             op;
      logic [FIELD_W-1:0] key;
      logic [FIELD_W-1:0] payload;
   } heap_req_type;

   typedef struct {
      logic [FIELD_W-1:0] key;
      logic [FIELD_W-1:0] payload;
   } heap_entry_type;

   typedef struct {
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic               head_valid;
      logic [FIELD_W-1:0] head_key;
      logic [FIELD_W-1:0] head_payload;
      logic [FIELD_W-1:0] removed_key;
      logic [FIELD_W-1:0] removed_payload;
   } heap_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_type = 1'b0;
   logic [FIELD_W-1:0] req_key = '0;
   logic [FIELD_W-1:0] req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0] rsp_count;
   logic               rsp_head_valid;
   logic [FIELD_W-1:0] rsp_head_key;
   logic [FIELD_W-1:0] rsp_head_payload;
   logic [FIELD_W-1:0] rsp_removed_key;
   logic [FIELD_W-1:0] rsp_removed_payload;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_max_first = 1'b0;

   heap_req_type    req_backlog[$];
   heap_result_type queue_outcomes[$];
   heap_req_type    shown_req;
   heap_entry_type  heap_mem[CAPACITY];
   int           heap_count = 0;
   logic         max_first_q = 1'b0;
   int           items_left = 0;
   int           plan_count = 0;
   int           errors = 0;
   int           cycle_count = 0;
   int           req_gap_pct = 34;
   int           rsp_stall_pct = 34;

   binary_heap_priority_queue_unit #(
      .CAPACITY(CAPACITY),
      .KEY_WIDTH(32),
      .PAYLOAD_WIDTH(32)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key(req_key),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_head_valid(rsp_head_valid),
      .rsp_head_key(rsp_head_key),
      .rsp_head_payload(rsp_head_payload),
      .rsp_removed_key(rsp_removed_key),
      .rsp_removed_payload(rsp_removed_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_max_first(csr_max_first)
   );

   always #4 clock = ~clock;

   function automatic bit key_precedes(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
      return max_first_q ? (a > b) : (a < b);
   endfunction

   // apply one request to the local heap and return the response it yields
   function automatic heap_result_type apply_heap_op(heap_req_type r);
      heap_result_type res;
      heap_entry_type  item;
      heap_entry_type  last;
      int           pos;
      int           parent;
      int           child;
      res.status          = STATUS_OK;
      res.removed_key     = '0;
      res.removed_payload = '0;
      if (r.op == OP_INSERT) begin
         if (heap_count >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            item.key     = r.key;
            item.payload = r.payload;
            heap_count++;
            pos    = heap_count;
            parent = pos / 2;
            while (parent != 0 && key_precedes(item.key, heap_mem[parent-1].key)) begin
               heap_mem[pos-1] = heap_mem[parent-1];
               pos    = parent;
               parent = pos / 2;
            end
            heap_mem[pos-1] = item;
         end
      end else begin
         if (heap_count == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.removed_key     = heap_mem[0].key;
            res.removed_payload = heap_mem[0].payload;
            heap_count--;
            last = heap_mem[heap_count];
            if (heap_count != 0) begin
               pos = 1;
               while (pos <= heap_count / 2) begin
                  child = pos * 2;
                  if (child < heap_count &&
                      !key_precedes(heap_mem[child-1].key, heap_mem[child].key))
                     child++;
                  if (key_precedes(last.key, heap_mem[child-1].key))
                     break;
                  heap_mem[pos-1] = heap_mem[child-1];
                  pos = child;
               end
               heap_mem[pos-1] = last;
            end
         end
      end
      res.count        = heap_count[COUNT_W-1:0];
      res.head_valid   = (heap_count != 0);
      res.head_key     = (heap_count != 0) ? heap_mem[0].key : '0;
      res.head_payload = (heap_count != 0) ? heap_mem[0].payload : '0;
      return res;
   endfunction

   task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin : drive
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            queue_outcomes.push_back(apply_heap_op(shown_req));
            items_left--;
         end
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               shown_req = req_backlog.pop_front();
               req_valid   <= 1'b1;
               req_type    <= shown_req.op;
               req_key     <= shown_req.key;
               req_payload <= shown_req.payload;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : observe
      heap_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (queue_outcomes.size() == 0) begin
               errors++;
               $display("%0t: response transfer with none expected, status %h count %0d",
                        $time, rsp_status, rsp_count);
            end else begin
               want = queue_outcomes.pop_front();
               check_field("status", FIELD_W'(want.status), FIELD_W'(rsp_status));
               check_field("count", FIELD_W'(want.count), FIELD_W'(rsp_count));
               check_field("head_valid", FIELD_W'(want.head_valid),
                           FIELD_W'(rsp_head_valid));
               check_field("head_key", want.head_key, rsp_head_key);
               check_field("head_payload", want.head_payload, rsp_head_payload);
               check_field("removed_key", want.removed_key, rsp_removed_key);
               check_field("removed_payload", want.removed_payload, rsp_removed_payload);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("FAIL binary_heap_priority_queue_unit");
         $finish;
      end
   end

   task automatic add_item(op_type op, logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] payload);
      heap_req_type r;
      r.op      = op;
      r.key     = key;
      r.payload = payload;
      req_backlog.push_back(r);
      items_left++;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (items_left != 0 || queue_outcomes.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_order(logic max_first);
      wait_idle();
      csr_valid     <= 1'b1;
      csr_max_first <= max_first;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      max_first_q = max_first;
   endtask

   function automatic logic [FIELD_W-1:0] rand_key();
      int pick;
      pick = $urandom_range(9);
      if (pick < 3)
         return $urandom_range(15);
      if (pick < 4) begin
         case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
         endcase
      end
      return $urandom();
   endfunction

   // fill and drain waves so both the full and empty ends are reached often
   task automatic gen_waves(int n);
      int made;
      int goal;
      int steps;
      int pick;
      bit up;
      bit ins;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(9);
         if (pick < 2)
            goal = 0;
         else if (pick < 4)
            goal = CAPACITY + $urandom_range(4);
         else
            goal = $urandom_range(1, CAPACITY - 1);
         up    = (goal > plan_count);
         steps = up ? goal - plan_count : plan_count - goal;
         if (goal == 0)
            steps += $urandom_range(3);
         for (int i = 0; i < steps && made < n; i++) begin
            ins = ($urandom_range(9) == 0) ? !up : up;
            add_item(ins ? OP_INSERT : OP_REMOVE, rand_key(), $urandom());
            if (ins && plan_count < CAPACITY)
               plan_count++;
            else if (!ins && plan_count > 0)
               plan_count--;
            made++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_order(1'b0);
      req_gap_pct   = 34;
      rsp_stall_pct = 34;
      add_item(OP_REMOVE, 32'h0, 32'h0);
      add_item(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      add_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      add_item(OP_INSERT, 32'h8000_0000, 32'h0000_0001);
      add_item(OP_INSERT, 32'h8000_0000, 32'h0000_0002);
      add_item(OP_INSERT, 32'h8000_0000, 32'h0000_0003);
      add_item(OP_INSERT, 32'h0000_0001, 32'hAAAA_AAAA);
      add_item(OP_INSERT, 32'h0000_0000, 32'h5555_5555);
      repeat (8) add_item(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      write_order(1'b1);
      add_item(OP_INSERT, 32'h0000_0005, 32'h1234_5678);
      add_item(OP_INSERT, 32'hFFFF_FFFF, 32'h8765_4321);
      add_item(OP_INSERT, 32'h0000_0005, 32'h0F0F_0F0F);
      add_item(OP_INSERT, 32'h0000_0000, 32'hF0F0_F0F0);
      repeat (4) add_item(OP_REMOVE, 32'h0, 32'h0);
      plan_count = 0;

      write_order(1'b0);
      gen_waves(WAVE_LEN);

      write_order(1'b1);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      gen_waves(WAVE_LEN);

      write_order(1'b0);
      req_gap_pct   = 34;
      rsp_stall_pct = 34;
      gen_waves(WAVE_LEN);

      write_order(1'b1);
      gen_waves(WAVE_LEN);

      wait_idle();
      repeat (30) @(posedge clock);
      if (errors == 0)
         $display("PASS binary_heap_priority_queue_unit");
      else
         $display("FAIL binary_heap_priority_queue_unit");
      $finish;
   end

endmodule

// ===== sim.f =====
design/hpq_pkg.sv
design/hpq_ram.sv
design/hpq_ctrl.sv
design/hpq_datapath.sv
design/binary_heap_priority_queue_unit.sv
design/hpq_checker.sv
test/binary_heap_priority_queue_unit_test.sv
